/* sv/nm3_pkg.sv */
package nm3_pkg;

    // build-time defaults
    localparam int MAX_WIDTH_DEF = 2048;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int CHANNELS   = 3;
    localparam int RGB_W      = PIX_W * CHANNELS;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_W      = 16;
    localparam int OUT_COL_W  = 11;
    localparam int SUM_W      = 11;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 56;

    // register reset values and lower limit of both dimensions
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam int                  MIN_DIM      = 3;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [RGB_W-1:0] rgb_t;

endpackage

/* sv/neighbour_mean_3x3_rgb.sv */
// 3x3 neighbour mean filter for 8-bit rgb pixels streamed in raster order. every input
// word is one pixel (blue, green, red); for each pixel not on the image border the block
// returns the truncated mean of its eight neighbours per channel (centre excluded, sum of
// eight shifted right by 3) together with the row and column of that centre pixel. the
// result for centre (r, c) leaves once pixel (r+1, c+1) has been taken, so border pixels
// and the last row and column give no output word. the block takes one pixel per clock
// unless m_tready stalls the output; the pixel and its line memory read are registered
// in stage 1 and the result in the output register. both previous lines live in one
// MAX_WIDTH x 48-bit single-write ram (upper line in the high half, middle line in the
// low half), read at the pixel's column in the accept cycle and written back one stage
// later; image_width is clamped to 3..MAX_WIDTH and image_height raised to 3. write the
// size registers only between frames or while idle; a counter beyond a new size wraps to
// zero at its next step. no clearing pass is needed after reset.
module neighbour_mean_3x3_rgb #(
    parameter int MAX_WIDTH = nm3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nm3_pkg::CFG_W-1:0]     cfg_data,

    // pixel in: blue [7:0], green [15:8], red [23:16]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nm3_pkg::S_DATA_W-1:0]  s_tdata,

    // result out: avg_blue [7:0], avg_green [15:8], avg_red [23:16],
    // out_row [39:24], out_col [50:40], zero fill [55:51]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nm3_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);      // column counter and ram address
    localparam int EW    = $clog2(MAX_WIDTH + 1);  // wide enough for MAX_WIDTH itself
    localparam int CW1   = COL_W + 1;
    localparam int RW    = nm3_pkg::HEIGHT_W;
    localparam int PW    = nm3_pkg::PIX_W;
    localparam int LW    = 2 * nm3_pkg::RGB_W;      // both lines in one ram word

    // ---------------------------------------------------------------- configuration
    logic [nm3_pkg::WIDTH_W-1:0]  width_reg,  width_next;
    logic [nm3_pkg::HEIGHT_W-1:0] height_reg, height_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (nm3_pkg::cfg_reg_t'(cfg_index))
                nm3_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data[nm3_pkg::WIDTH_W-1:0];
                nm3_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data[nm3_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: width clamped to 3..MAX_WIDTH, height raised to 3
    logic [EW-1:0] eff_width;
    logic [RW-1:0] eff_height;

    always_comb
    begin
        if (32'(width_reg) < nm3_pkg::MIN_DIM)
        begin
            eff_width = EW'(nm3_pkg::MIN_DIM);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW'(width_reg);
        end
        eff_height = (32'(height_reg) < nm3_pkg::MIN_DIM) ? RW'(nm3_pkg::MIN_DIM) : height_reg;
    end

    // ---------------------------------------------------------------- handshake control
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;      // stage 1 may move into the output register this cycle
    logic accept;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------- raster counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW1-1:0]   col_inc;
    logic [RW:0]      row_inc;

    always_comb
    begin
        col_inc  = CW1'(col_reg) + CW1'(1);
        row_inc  = {1'b0, row_reg} + 17'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (32'(col_inc) >= 32'(eff_width))
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, eff_height}) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- stage 1 registers
    nm3_pkg::rgb_t    pix_s1_reg, pix_s1_next;
    logic [COL_W-1:0] col_s1_reg, col_s1_next;
    logic [RW-1:0]    row_s1_reg, row_s1_next;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        pix_s1_next   = pix_s1_reg;
        col_s1_next   = col_s1_reg;
        row_s1_next   = row_s1_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            pix_s1_next   = s_tdata[nm3_pkg::RGB_W-1:0];
            col_s1_next   = col_reg;
            row_s1_next   = row_reg;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- line memory
    // a column's entry is read in the accept cycle and rewritten when that word leaves
    // stage 1; the next access to the same column comes at least three words later
    logic          line_we;
    logic [LW-1:0] line_wdata;
    logic [LW-1:0] line_rdata;
    nm3_pkg::rgb_t up_pix, mid_pix;

    assign up_pix     = line_rdata[LW-1:nm3_pkg::RGB_W];
    assign mid_pix    = line_rdata[nm3_pkg::RGB_W-1:0];
    assign line_we    = s1_valid_reg && advance;
    assign line_wdata = {mid_pix, pix_s1_reg};

    nm3_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (col_s1_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // ---------------------------------------------------------------- window
    // two older columns held in registers, newest column is {up, mid, pixel}
    nm3_pkg::rgb_t win0_reg [3];
    nm3_pkg::rgb_t win1_reg [3];
    nm3_pkg::rgb_t win0_next [3];
    nm3_pkg::rgb_t win1_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win0_next[i] = win0_reg[i];
            win1_next[i] = win1_reg[i];
        end
        if (line_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win0_next[i] = win1_reg[i];
            end
            win1_next[0] = up_pix;
            win1_next[1] = mid_pix;
            win1_next[2] = pix_s1_reg;
        end
    end

    // per channel sum of the eight neighbours, centre win1[1] left out
    logic [nm3_pkg::SUM_W-1:0] nsum [nm3_pkg::CHANNELS];
    logic                      emit;

    always_comb
    begin
        for (int ch = 0; ch < nm3_pkg::CHANNELS; ch++)
        begin
            nsum[ch] = nm3_pkg::SUM_W'(win0_reg[0][ch*PW +: PW])
                     + nm3_pkg::SUM_W'(win0_reg[1][ch*PW +: PW])
                     + nm3_pkg::SUM_W'(win0_reg[2][ch*PW +: PW])
                     + nm3_pkg::SUM_W'(win1_reg[0][ch*PW +: PW])
                     + nm3_pkg::SUM_W'(win1_reg[2][ch*PW +: PW])
                     + nm3_pkg::SUM_W'(up_pix[ch*PW +: PW])
                     + nm3_pkg::SUM_W'(mid_pix[ch*PW +: PW])
                     + nm3_pkg::SUM_W'(pix_s1_reg[ch*PW +: PW]);
        end
        emit = (row_s1_reg >= RW'(2)) && (col_s1_reg >= COL_W'(2));
    end

    // ---------------------------------------------------------------- output register
    nm3_pkg::rgb_t                   avg_reg, avg_next;
    logic [RW-1:0]                   out_row_reg, out_row_next;
    logic [nm3_pkg::OUT_COL_W-1:0]   out_col_reg, out_col_next;
    logic [31:0]                     col_minus;

    always_comb
    begin
        col_minus      = 32'(col_s1_reg) - 32'd1;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg && emit;
            if (s1_valid_reg && emit)
            begin
                for (int ch = 0; ch < nm3_pkg::CHANNELS; ch++)
                begin
                    avg_next[ch*PW +: PW] = nsum[ch][nm3_pkg::SUM_W-1:3];
                end
                out_row_next = row_s1_reg - RW'(1);
                out_col_next = col_minus[nm3_pkg::OUT_COL_W-1:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_col_reg, out_row_reg, avg_reg};

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= nm3_pkg::WIDTH_RESET;
            height_reg    <= nm3_pkg::HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                win0_reg[i] <= win0_next[i];
                win1_reg[i] <= win1_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_s1_reg  <= pix_s1_next;
        col_s1_reg  <= col_s1_next;
        row_s1_reg  <= row_s1_next;
        avg_reg     <= avg_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
    end

`ifndef NO_ASSERTIONS
    // write-back and a new read never hit the same line entry in one cycle
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (line_we && accept) |-> (col_reg != col_s1_reg))
        else $error("line ram read and write collide on one entry");

    // a held stage 1 word blocks new reads so the ram output stays valid
    a_hold_blocks_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !accept)
        else $error("pixel accepted while stage 1 is stalled");

    // results are never for a border pixel
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_row_reg != '0) && (out_col_reg != '0))
        else $error("result for a border pixel");

    // a word in stage 1 that can move is always written back the next edge
    a_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !accept) |=> !s1_valid_reg)
        else $error("stage 1 word not retired");
`endif

endmodule

/* sv/nm3_ram.sv */
module nm3_ram #(
    parameter int WIDTH = nm3_pkg::RGB_W,
    parameter int DEPTH = nm3_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
